/* sv/akf_pkg.sv */
// Package for the analog key filter: sizes, register codes and word types.
// Used by every module of the block except akf_ram; depends on nothing.

package akf_pkg;

    localparam int KEY_COUNT   = 64;
    localparam int SAMPLE_BITS = 12;

    localparam int KEY_W     = 6;
    localparam int FIELD_W   = 12;
    localparam int Q8_BITS   = 8;
    localparam int LEVEL_W   = SAMPLE_BITS;
    localparam int AVG_W     = SAMPLE_BITS + Q8_BITS;
    localparam int MEM_W     = AVG_W + 1;
    localparam int ADDR_W    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int SHIFT_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(8);

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PRESET = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH_SHIFT      = 3'd0,
        CFG_RELEASED_LEVEL    = 3'd1,
        CFG_PRESSED_LEVEL     = 3'd2,
        CFG_PRESS_THRESHOLD   = 3'd3,
        CFG_RELEASE_THRESHOLD = 3'd4
    } akf_cfg_idx_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] smooth_shift;
        logic [FIELD_W-1:0] released_level;
        logic [FIELD_W-1:0] pressed_level;
        logic [FIELD_W-1:0] press_threshold;
        logic [FIELD_W-1:0] release_threshold;
    } akf_cfg_t;

    typedef struct packed {
        logic               opcode;
        logic [KEY_W-1:0]   key_index;
        logic [FIELD_W-1:0] sample;
    } akf_in_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key_out;
        logic [FIELD_W-1:0] filtered_level;
        logic               pressed;
        logic               changed;
    } akf_out_t;

endpackage

/* sv/analog_key_filter_hysteresis.sv */
// Top level of the per-key analog filter with hysteresis.
// Depends on akf_pkg, akf_ram, akf_cfg_regs and akf_update.
//
//   Channel   Ports                                       Direction  Word
//   input     s_valid s_ready s_data                      in         akf_in_t
//   result    m_valid m_ready m_data                      out        akf_out_t
//   config    cfg_valid cfg_ready cfg_index cfg_data      in         index + data
//
// One word per cycle is sustained while m_ready stays high; each accepted word passes
// through the update stage into the output register. The rate is set by the
// read-modify-write of the state RAM, with the previous write forwarded when the same
// key follows. Reset clears the per-key valid bits; no clearing pass is run.
// A stalled result holds the output register while one more word waits in the
// update stage; input ready then drops.

module analog_key_filter_hysteresis import akf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  akf_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output akf_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    akf_cfg_t cfg;

    logic               s_acc;
    logic               st1_adv;
    logic               in_range;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  st1_addr;
    logic               wr_en;
    logic [MEM_W-1:0]   ram_rdata;
    logic [MEM_W-1:0]   cur_word;
    logic [MEM_W-1:0]   next_word;
    logic [FIELD_W-1:0] upd_level;
    logic               upd_pressed;
    logic               upd_changed;
    logic               fwd_hit;

    logic               st1_valid_reg;
    logic               st1_valid_next;
    logic               st1_op_reg;
    logic [KEY_W-1:0]   st1_key_reg;
    logic [FIELD_W-1:0] st1_sample_reg;
    logic               st1_in_range_reg;
    logic               st1_entry_vld_reg;

    logic               fwd_valid_reg;
    logic               fwd_valid_next;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic [MEM_W-1:0]   fwd_data_reg;

    logic [KEY_COUNT-1:0] entry_valid_reg;
    logic [KEY_COUNT-1:0] entry_valid_next;

    logic               m_valid_reg;
    logic               m_valid_next;
    akf_out_t           m_data_reg;
    akf_out_t           m_data_next;

    akf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign st1_adv  = st1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready  = ~st1_valid_reg | st1_adv;
    assign s_acc    = s_valid & s_ready;
    assign in_range = 32'(s_data.key_index) < KEY_COUNT;
    assign rd_addr  = ADDR_W'(s_data.key_index);
    assign st1_addr = ADDR_W'(st1_key_reg);
    assign wr_en    = st1_adv & st1_in_range_reg;

    akf_ram #(
        .WIDTH (MEM_W),
        .DEPTH (KEY_COUNT)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (st1_addr),
        .wdata (next_word),
        .re    (s_acc & in_range),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        fwd_hit = fwd_valid_reg && (fwd_addr_reg == st1_addr);
        if (fwd_hit) begin
            cur_word = fwd_data_reg;
        end else if (st1_entry_vld_reg) begin
            cur_word = ram_rdata;
        end else begin
            cur_word = '0;
        end
    end

    akf_update u_update (
        .cfg       (cfg),
        .opcode    (st1_op_reg),
        .sample    (st1_sample_reg),
        .cur_word  (cur_word),
        .next_word (next_word),
        .level     (upd_level),
        .pressed   (upd_pressed),
        .changed   (upd_changed)
    );

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (s_acc) begin
            st1_valid_next = 1'b1;
        end else if (st1_adv) begin
            st1_valid_next = 1'b0;
        end

        fwd_valid_next = s_acc ? wr_en : fwd_valid_reg;

        entry_valid_next = entry_valid_reg;
        if (wr_en) begin
            entry_valid_next[st1_addr] = 1'b1;
        end

        m_valid_next = m_valid_reg;
        if (st1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        m_data_next.key_out        = st1_key_reg;
        m_data_next.filtered_level = st1_in_range_reg ? upd_level : '0;
        m_data_next.pressed        = st1_in_range_reg & upd_pressed;
        m_data_next.changed        = st1_in_range_reg & upd_changed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg   <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            st1_valid_reg   <= st1_valid_next;
            fwd_valid_reg   <= fwd_valid_next;
            entry_valid_reg <= entry_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st1_op_reg        <= s_data.opcode;
            st1_key_reg       <= s_data.key_index;
            st1_sample_reg    <= s_data.sample;
            st1_in_range_reg  <= in_range;
            st1_entry_vld_reg <= entry_valid_reg[rd_addr];
            fwd_addr_reg      <= st1_addr;
            fwd_data_reg      <= next_word;
        end
        if (st1_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_write_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> entry_valid_reg[$past(st1_addr)])
        else $error("State word written but its entry is not marked valid.");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("Input taken while both pipeline stages are blocked.");

    a_result_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st1_valid_reg))
        else $error("Result produced without a word in the update stage.");
`endif

endmodule

/* sv/akf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.

module akf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/akf_cfg_regs.sv */
// Configuration register file of the key filter, written one word at a time.
// Depends on akf_pkg for the register codes and the settings struct.

module akf_cfg_regs import akf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    output akf_cfg_t             cfg
);

    akf_cfg_t cfg_reg;
    akf_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SMOOTH_SHIFT:      cfg_next.smooth_shift      = cfg_data[SHIFT_W-1:0];
                CFG_RELEASED_LEVEL:    cfg_next.released_level    = cfg_data;
                CFG_PRESSED_LEVEL:     cfg_next.pressed_level     = cfg_data;
                CFG_PRESS_THRESHOLD:   cfg_next.press_threshold   = cfg_data;
                CFG_RELEASE_THRESHOLD: cfg_next.release_threshold = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.smooth_shift      <= SHIFT_W'(2);
            cfg_reg.released_level    <= FIELD_W'(0);
            cfg_reg.pressed_level     <= FIELD_W'(4095);
            cfg_reg.press_threshold   <= FIELD_W'(2400);
            cfg_reg.release_threshold <= FIELD_W'(2000);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/akf_update.sv */
// Moving-average update and hysteresis decision for one key word.
// Depends on akf_pkg for widths, opcodes and the settings struct.

module akf_update import akf_pkg::*; (
    input  akf_cfg_t           cfg,
    input  logic               opcode,
    input  logic [FIELD_W-1:0] sample,
    input  logic [MEM_W-1:0]   cur_word,
    output logic [MEM_W-1:0]   next_word,
    output logic [FIELD_W-1:0] level,
    output logic               pressed,
    output logic               changed
);

    logic [AVG_W-1:0]        cur_avg;
    logic [AVG_W-1:0]        target;
    logic [AVG_W-1:0]        next_avg;
    logic [AVG_W:0]          sum;
    logic signed [AVG_W:0]   diff;
    logic signed [AVG_W:0]   step;
    logic [SHIFT_W-1:0]      shift;
    logic [LEVEL_W-1:0]      lvl_sample;
    logic [LEVEL_W-1:0]      new_level;
    logic                    was_down;
    logic                    after;
    logic                    normal;
    logic                    hit_press;
    logic                    hit_release;

    always_comb begin
        cur_avg    = cur_word[AVG_W-1:0];
        was_down   = cur_word[AVG_W];
        shift      = (cfg.smooth_shift > MAX_SHIFT) ? MAX_SHIFT : cfg.smooth_shift;
        lvl_sample = LEVEL_W'(sample);
        target     = {lvl_sample, {Q8_BITS{1'b0}}};
        diff       = $signed({1'b0, target}) - $signed({1'b0, cur_avg});
        step       = diff >>> shift;
        sum        = {1'b0, cur_avg} + $unsigned(step);

        if (opcode == OP_PRESET) begin
            next_avg = AVG_W'({cfg.released_level, {Q8_BITS{1'b0}}});
        end else begin
            next_avg = sum[AVG_W-1:0];
        end
        new_level = next_avg[AVG_W-1:Q8_BITS];

        normal = cfg.pressed_level >= cfg.released_level;
        if (normal) begin
            hit_press   = 32'(new_level) >= 32'(cfg.press_threshold);
            hit_release = 32'(new_level) <= 32'(cfg.release_threshold);
        end else begin
            hit_press   = 32'(new_level) <= 32'(cfg.press_threshold);
            hit_release = 32'(new_level) >= 32'(cfg.release_threshold);
        end

        if (opcode == OP_PRESET) begin
            after = 1'b0;
        end else if (!was_down) begin
            after = hit_press;
        end else begin
            after = !hit_release;
        end
    end

    assign next_word = {after, next_avg};
    assign level     = FIELD_W'(new_level);
    assign pressed   = after;
    assign changed   = was_down ^ after;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for analog_key_filter_hysteresis: drives sample and preset words
// at random pace (steadily in one phase), predicts each key's moving average and pressed flag,
// and checks every result. Depends on akf_pkg and the RTL of the block.

module tb_top;
    import akf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 34;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    akf_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    akf_out_t             m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FIELD_W-1:0]   cfg_data  = '0;

    akf_in_t  sample_words[$];
    akf_out_t key_reports[$];

    logic [AVG_W-1:0]   level_q8[KEY_COUNT];
    logic               key_held[KEY_COUNT];
    logic [SHIFT_W-1:0] shift_set    = 4'd2;
    logic [FIELD_W-1:0] released_set = 12'd0;
    logic [FIELD_W-1:0] pressed_set  = 12'd4095;
    logic [FIELD_W-1:0] press_at     = 12'd2400;
    logic [FIELD_W-1:0] release_at   = 12'd2000;

    bit steady = 1'b0;
    int errors = 0;
    int words_sent = 0;
    int reports_checked = 0;
    int flag_changes = 0;
    int settings_used = 1;
    int cycles = 0;

    analog_key_filter_hysteresis i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            level_q8[k] = '0;
            key_held[k] = 1'b0;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic akf_out_t filter_key(akf_in_t w);
        akf_out_t    report;
        int unsigned sh;
        int unsigned cur;
        int unsigned target;
        int unsigned mag;
        int unsigned stp;
        int unsigned nxt;
        int unsigned lvl;
        logic        was_held;
        logic        normal;
        sh       = 32'((shift_set > MAX_SHIFT) ? MAX_SHIFT : shift_set);
        cur      = 32'(level_q8[w.key_index]);
        was_held = key_held[w.key_index];
        normal   = pressed_set >= released_set;
        if (w.opcode == OP_PRESET) begin
            level_q8[w.key_index] = {released_set, 8'h00};
            key_held[w.key_index] = 1'b0;
        end else begin
            target = 32'(w.sample) << 8;
            if (target >= cur) begin
                nxt = cur + ((target - cur) >> sh);
            end else begin
                mag = cur - target;
                stp = (mag + (32'd1 << sh) - 1) >> sh;
                nxt = (stp > cur) ? 0 : cur - stp;
            end
            level_q8[w.key_index] = AVG_W'(nxt);
            lvl = 32'(level_q8[w.key_index] >> 8);
            if (!was_held) begin
                if (normal ? (lvl >= press_at) : (lvl <= press_at)) begin
                    key_held[w.key_index] = 1'b1;
                end
            end else if (normal ? (lvl <= release_at) : (lvl >= release_at)) begin
                key_held[w.key_index] = 1'b0;
            end
        end
        report.key_out        = w.key_index;
        report.filtered_level = level_q8[w.key_index][AVG_W-1:8];
        report.pressed        = key_held[w.key_index];
        report.changed        = was_held != key_held[w.key_index];
        return report;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (sample_words.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_valid <= 1'b1;
                s_data  <= sample_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        akf_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (key_reports.size() == 0) begin
                    $display("%0t: result with no word outstanding, expected none, got %p",
                             $time, m_data);
                    errors++;
                end else begin
                    want = key_reports.pop_front();
                    reports_checked++;
                    if (m_data.key_out !== want.key_out) begin
                        $display("%0t: key_out expected %0d got %0d",
                                 $time, want.key_out, m_data.key_out);
                        errors++;
                    end
                    if (m_data.filtered_level !== want.filtered_level) begin
                        $display("%0t: filtered_level of key %0d expected %0d got %0d",
                                 $time, want.key_out, want.filtered_level, m_data.filtered_level);
                        errors++;
                    end
                    if (m_data.pressed !== want.pressed) begin
                        $display("%0t: pressed of key %0d expected %0b got %0b",
                                 $time, want.key_out, want.pressed, m_data.pressed);
                        errors++;
                    end
                    if (m_data.changed !== want.changed) begin
                        $display("%0t: changed of key %0d expected %0b got %0b",
                                 $time, want.key_out, want.changed, m_data.changed);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = filter_key(s_data);
                key_reports.push_back(want);
                words_sent++;
                if (want.changed) begin
                    flag_changes++;
                end
            end
        end
    end

    task automatic push_word(logic op, int key, int level);
        akf_in_t w;
        w.opcode    = op;
        w.key_index = KEY_W'(key);
        w.sample    = FIELD_W'(level);
        sample_words.push_back(w);
    endtask

    function automatic int near_level(int centre, int spread);
        int v;
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) begin
            v = 0;
        end
        if (v > 4095) begin
            v = 4095;
        end
        return v;
    endfunction

    task automatic write_reg(akf_cfg_idx_t idx, logic [FIELD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SMOOTH_SHIFT:      shift_set    = value[SHIFT_W-1:0];
            CFG_RELEASED_LEVEL:    released_set = value;
            CFG_PRESSED_LEVEL:     pressed_set  = value;
            CFG_PRESS_THRESHOLD:   press_at     = value;
            CFG_RELEASE_THRESHOLD: release_at   = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_settings(int sh, int rel, int prs, int pth, int rth);
        write_reg(CFG_SMOOTH_SHIFT, FIELD_W'(sh));
        write_reg(CFG_RELEASED_LEVEL, FIELD_W'(rel));
        write_reg(CFG_PRESSED_LEVEL, FIELD_W'(prs));
        write_reg(CFG_PRESS_THRESHOLD, FIELD_W'(pth));
        write_reg(CFG_RELEASE_THRESHOLD, FIELD_W'(rth));
        settings_used++;
    endtask

    task automatic wait_drained();
        while (sample_words.size() > 0 || s_valid || key_reports.size() > 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic fill_phase(int count);
        int queued;
        int key;
        int run;
        int spread;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(0, 99) < 80) begin
                key    = $urandom_range(0, KEY_COUNT - 1);
                run    = $urandom_range(1, 12);
                spread = $urandom_range(0, 300);
                if ($urandom_range(0, 1)) begin
                    push_word(OP_PRESET, key, $urandom_range(0, 4095));
                    queued++;
                end
                for (int i = 0; i < run; i++) begin
                    push_word(OP_UPDATE, key, near_level(int'(pressed_set), spread));
                end
                for (int i = 0; i < run; i++) begin
                    push_word(OP_UPDATE, key, near_level(int'(released_set), spread));
                end
                queued += 2 * run;
            end else begin
                push_word(1'($urandom_range(0, 1)), $urandom_range(0, KEY_COUNT - 1),
                          $urandom_range(0, 4095));
                queued++;
            end
        end
    endtask

    initial begin
        int rel;
        int prs;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 5; i++) begin
            push_word(OP_UPDATE, 0, 4095);
        end
        for (int i = 0; i < 6; i++) begin
            push_word(OP_UPDATE, 0, 0);
        end
        for (int i = 0; i < 4; i++) begin
            push_word(OP_UPDATE, 0, 4095);
        end
        push_word(OP_PRESET, 0, 0);
        push_word(OP_PRESET, 63, 4095);
        push_word(OP_UPDATE, 63, 4095);
        push_word(OP_UPDATE, 63, 4095);
        push_word(OP_UPDATE, 42, 12'hAAA);
        push_word(OP_UPDATE, 21, 12'h555);
        push_word(OP_PRESET, 21, 12'hFFF);
        push_word(OP_UPDATE, 63, 0);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_settings(0, 0, 4095, 2400, 2000);
                1: apply_settings(15, 4095, 0, 1000, 1500);
                2: apply_settings(8, 2048, 2048, 0, 4095);
                3: apply_settings(1, 100, 3900, 4095, 0);
                default: begin
                    rel = $urandom_range(0, 4095);
                    prs = $urandom_range(0, 4095);
                    apply_settings($urandom_range(0, 15), rel, prs,
                                   (rel * 4 + prs * 6) / 10, (rel * 6 + prs * 4) / 10);
                end
            endcase
            steady = (phase == 5);
            fill_phase(66);
            wait_drained();
            steady = 1'b0;
        end

        $display("Run covered %0d words and %0d checked results over %0d filter settings,",
                 words_sent, reports_checked, settings_used);
        $display("including %0d pressed flag changes and %0d mismatches.",
                 flag_changes, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
